>>> hw/rtl/pfs_pkg.sv
// Shared types and constants for the pairwise float sum stream block.
// Holds the controller-to-datapath command and status structs and binary64 constants.
// Depends on nothing.
package pfs_pkg;

   // Binary64 field widths and the default NaN that an invalid operation produces.
   localparam int unsigned FP_WIDTH     = 64;
   localparam int unsigned COUNT_WIDTH  = 32;
   localparam int unsigned FOLD_LIMIT   = 32;
   localparam logic [63:0] FP_QNAN      = 64'hFFF8_0000_0000_0000;
   localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

   // Source of a write into the partial sum memory.
   typedef enum logic [1:0] {
      WR_ITEM,
      WR_SUM,
      WR_ACC
   } wr_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       take;       // Latch an accepted item and update the count.
      logic       wr_en;      // Write the memory at the current level.
      wr_sel_type wr_sel;
      logic       rd_en;      // Read the memory at the current level.
      logic       add_start;  // Start the shared adder.
      logic       fold_mode;  // Operand order: fold is acc + level, chain is level + acc.
      logic       acc_sum;    // Load the accumulator from the adder result.
      logic       lvl_inc;    // Step to the next level.
      logic       fold_init;  // Clear accumulator to +0 and level to zero.
      logic       emit;       // Load the result register and clear the count.
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic item_no_carry;  // Count before this item is even: the item loads level 0.
      logic last;           // The item being worked on closes its stream.
      logic lvl_past_top;   // Level index is beyond the top level.
      logic lvl_lt_ones;    // Level index is below the trailing ones of the index.
      logic fold_end;       // All levels that take part in the fold are done.
      logic cnt_bit;        // Count bit at the current level is set.
      logic add_done;       // Adder result is ready.
      logic rsp_full;       // Result register still holds an untaken item.
   } status_type;

endpackage

>>> hw/rtl/pfs_if.sv
// Valid/ready channel interfaces for the pairwise float sum stream block.
// One interface for the addend channel and one for the result channel; no dependencies.
interface pfs_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] value_bits;
   logic        is_last;

   modport source (output valid, output value_bits, output is_last, input ready);
   modport sink (input valid, input value_bits, input is_last, output ready);
endinterface

interface pfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] total_bits;
   logic [31:0] item_total;

   modport source (output valid, output total_bits, output item_total, input ready);
   modport sink (input valid, input total_bits, input item_total, output ready);
endinterface

>>> hw/rtl/pfs_fadd.sv
// Multi-cycle binary64 adder with round-to-nearest-even, one operation at a time.
// Stages: align, add, leading zero count, normalize shift, round. Uses pfs_pkg.
module pfs_fadd
   import pfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] sum
);

   typedef enum logic [2:0] {
      A_IDLE,
      A_ALIGN,
      A_SUM,
      A_LZC,
      A_SHIFT,
      A_ROUND
   } astate_type;

   astate_type  state_ff, state_in;
   logic [63:0] a_ff, b_ff;
   logic [55:0] big_ff, small_ff;
   logic [11:0] exp_ff;
   logic        sign_ff, sub_ff, spec_ff;
   logic [63:0] spec_val_ff;
   logic [56:0] sum_ff;
   logic [55:0] norm_ff;
   logic [5:0]  lz_ff;
   logic        zero_ff;
   logic [63:0] res_ff;
   logic        done_ff;

   // Leading zero count over the 56-bit working mantissa.
   function automatic logic [5:0] clz56(input logic [55:0] v);
      logic [5:0] n;
      logic       hit;
      n   = 6'd56;
      hit = 1'b0;
      for (int i = 55; i >= 0; i--) begin
         if (!hit && v[i]) begin
            n   = 6'(55 - i);
            hit = 1'b1;
         end
      end
      return n;
   endfunction

   // Alignment: order operands by magnitude and shift the smaller one right with sticky.
   logic        a_big;
   logic [63:0] bg, sm;
   logic [10:0] eg, es, d;
   logic [55:0] mg, ms, ms_sh, ms_aln;
   logic        st;
   logic        a_nan, b_nan, a_inf, b_inf;
   logic        spec;
   logic [63:0] spec_val;

   always_comb begin
      a_big = a_ff[62:0] >= b_ff[62:0];
      bg    = a_big ? a_ff : b_ff;
      sm    = a_big ? b_ff : a_ff;
      eg    = (bg[62:52] == 11'd0) ? 11'd1 : bg[62:52];
      es    = (sm[62:52] == 11'd0) ? 11'd1 : sm[62:52];
      mg    = {|bg[62:52], bg[51:0], 3'b000};
      ms    = {|sm[62:52], sm[51:0], 3'b000};
      d     = eg - es;
      if (d > 11'd55) begin
         ms_sh = 56'd0;
         st    = |ms;
      end else begin
         ms_sh = ms >> d;
         st    = |(ms & ((56'd1 << d) - 56'd1));
      end
      ms_aln = {ms_sh[55:1], ms_sh[0] | st};

      // NaN and infinity handling; a NaN in the first operand takes priority.
      a_nan    = (&a_ff[62:52]) && (|a_ff[51:0]);
      b_nan    = (&b_ff[62:52]) && (|b_ff[51:0]);
      a_inf    = (&a_ff[62:52]) && !(|a_ff[51:0]);
      b_inf    = (&b_ff[62:52]) && !(|b_ff[51:0]);
      spec     = a_nan || b_nan || a_inf || b_inf;
      spec_val = 64'd0;
      if (a_nan) begin
         spec_val = a_ff | 64'h0008_0000_0000_0000;
      end else if (b_nan) begin
         spec_val = b_ff | 64'h0008_0000_0000_0000;
      end else if (a_inf && b_inf && (a_ff[63] != b_ff[63])) begin
         spec_val = FP_QNAN;
      end else if (a_inf) begin
         spec_val = a_ff;
      end else begin
         spec_val = b_ff;
      end
   end

   // Normalize shift, limited so that the exponent does not drop below the subnormal one.
   logic [11:0] exp_m1, sh;

   always_comb begin
      exp_m1 = exp_ff - 12'd1;
      sh     = (12'(lz_ff) < exp_m1) ? 12'(lz_ff) : exp_m1;
   end

   // Rounding to nearest even and packing.
   logic [52:0] mant;
   logic        rup;
   logic [53:0] mr;
   logic [52:0] mant_f;
   logic [11:0] ef;
   logic [63:0] packed_res;

   always_comb begin
      mant = norm_ff[55:3];
      rup  = norm_ff[2] && (norm_ff[1] || norm_ff[0] || mant[0]);
      mr   = {1'b0, mant} + 54'(rup);
      if (mr[53]) begin
         mant_f = mr[53:1];
         ef     = exp_ff + 12'd1;
      end else begin
         mant_f = mr[52:0];
         ef     = exp_ff;
      end
      if (spec_ff) begin
         packed_res = spec_val_ff;
      end else if (zero_ff) begin
         packed_res = {sub_ff ? 1'b0 : sign_ff, 63'd0};
      end else if (ef >= 12'd2047) begin
         packed_res = {sign_ff, 11'h7FF, 52'd0};
      end else if (!mant_f[52]) begin
         packed_res = {sign_ff, 11'd0, mant_f[51:0]};
      end else begin
         packed_res = {sign_ff, ef[10:0], mant_f[51:0]};
      end
   end

   // Stage sequencing.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         A_IDLE:  if (start) state_in = A_ALIGN;
         A_ALIGN: state_in = A_SUM;
         A_SUM:   state_in = A_LZC;
         A_LZC:   state_in = A_SHIFT;
         A_SHIFT: state_in = A_ROUND;
         A_ROUND: state_in = A_IDLE;
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == A_ROUND);
      end
   end

   // Datapath registers of the adder.
   always_ff @(posedge clock) begin
      case (state_ff)
         A_IDLE: begin
            if (start) begin
               a_ff <= op_a;
               b_ff <= op_b;
            end
         end
         A_ALIGN: begin
            big_ff      <= mg;
            small_ff    <= ms_aln;
            exp_ff      <= {1'b0, eg};
            sign_ff     <= bg[63];
            sub_ff      <= a_ff[63] ^ b_ff[63];
            spec_ff     <= spec;
            spec_val_ff <= spec_val;
         end
         A_SUM: begin
            sum_ff <= sub_ff ? ({1'b0, big_ff} - {1'b0, small_ff})
                             : ({1'b0, big_ff} + {1'b0, small_ff});
         end
         A_LZC: begin
            zero_ff <= (sum_ff == 57'd0);
            if (sum_ff[56]) begin
               norm_ff <= {sum_ff[56:2], |sum_ff[1:0]};
               exp_ff  <= exp_ff + 12'd1;
               lz_ff   <= 6'd0;
            end else begin
               norm_ff <= sum_ff[55:0];
               lz_ff   <= clz56(sum_ff[55:0]);
            end
         end
         A_SHIFT: begin
            norm_ff <= norm_ff << sh;
            exp_ff  <= exp_ff - sh;
         end
         A_ROUND: res_ff <= packed_res;
         default: ;
      endcase
   end

   assign done = done_ff;
   assign sum  = res_ff;

endmodule

>>> hw/rtl/pfs_ctrl.sv
// Controller state machine for the pairwise float sum stream block.
// Sequences the carry chain and the final fold through command and status structs; uses pfs_pkg.
module pfs_ctrl
   import pfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_WR0,
      S_RD,
      S_ADD,
      S_AWAIT,
      S_DEC,
      S_WRL,
      S_CHK,
      S_FCHK,
      S_FRD,
      S_FADD,
      S_FWAIT,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands for the current state.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.wr_sel = WR_ITEM;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = status.item_no_carry ? S_WR0 : S_RD;
            end
         end
         // Even index: the item simply loads level 0.
         S_WR0: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_ITEM;
            state_in   = S_CHK;
         end
         // Carry chain: level j accumulates the level below it.
         S_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_ADD;
         end
         S_ADD: begin
            cmd.add_start = 1'b1;
            state_in      = S_AWAIT;
         end
         S_AWAIT: begin
            if (status.add_done) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WR_SUM;
               cmd.acc_sum = 1'b1;
               cmd.lvl_inc = 1'b1;
               state_in    = S_DEC;
            end
         end
         S_DEC: begin
            if (status.lvl_past_top) begin
               state_in = S_CHK;
            end else if (status.lvl_lt_ones) begin
               state_in = S_RD;
            end else begin
               state_in = S_WRL;
            end
         end
         // End of the carry: the level above the run of ones is loaded.
         S_WRL: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_ACC;
            state_in   = S_CHK;
         end
         S_CHK: begin
            if (status.last) begin
               cmd.fold_init = 1'b1;
               state_in      = S_FCHK;
            end else begin
               state_in = S_IDLE;
            end
         end
         // Fold the levels whose count bit is set, lowest first.
         S_FCHK: begin
            if (status.fold_end) begin
               state_in = S_EMIT;
            end else if (status.cnt_bit) begin
               state_in = S_FRD;
            end else begin
               cmd.lvl_inc = 1'b1;
            end
         end
         S_FRD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_FADD;
         end
         S_FADD: begin
            cmd.add_start = 1'b1;
            cmd.fold_mode = 1'b1;
            state_in      = S_FWAIT;
         end
         S_FWAIT: begin
            cmd.fold_mode = 1'b1;
            if (status.add_done) begin
               cmd.acc_sum = 1'b1;
               cmd.lvl_inc = 1'b1;
               state_in    = S_FCHK;
            end
         end
         S_EMIT: begin
            if (!status.rsp_full) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/pfs_dpath.sv
// Datapath of the pairwise float sum stream block: partial sum memory, count,
// accumulator, level index, result register and the shared adder. Uses pfs_pkg, pfs_fadd.
module pfs_dpath
   import pfs_pkg::*;
#(
   parameter int unsigned LEVELS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [63:0] req_value_bits,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_total_bits,
   output logic [31:0] rsp_item_total
);

   localparam int unsigned AW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int unsigned LW     = $clog2(LEVELS + 1);
   localparam int unsigned TOP    = LEVELS - 1;
   localparam int unsigned FOLD_N = (LEVELS < FOLD_LIMIT) ? LEVELS : FOLD_LIMIT;

   logic [63:0] mem [LEVELS];
   logic [63:0] rd_ff;
   logic [63:0] x_ff, acc_ff;
   logic [31:0] count_ff;
   logic [5:0]  ones_ff;
   logic [LW-1:0] lvl_ff;
   logic        last_ff;
   logic        rsp_valid_ff;
   logic [63:0] total_ff;
   logic [31:0] item_total_ff;

   logic [AW-1:0] addr;
   logic [63:0]   wdata;
   logic [63:0]   add_a, add_b, add_sum;
   logic          add_done;
   logic [5:0]    ones_now;
   logic [31:0]   count_inc;
   logic [31:0]   count_sh;

   // Trailing ones of the count before the item: the length of the carry.
   always_comb begin
      ones_now = 6'd32;
      for (int i = 31; i >= 0; i--) begin
         if (!count_ff[i]) begin
            ones_now = 6'(i);
         end
      end
      count_inc = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 32'd1;
      count_sh  = count_ff >> lvl_ff;
   end

   assign addr = lvl_ff[AW-1:0];

   // Memory write data by source.
   always_comb begin
      case (cmd.wr_sel)
         WR_ITEM: wdata = x_ff;
         WR_SUM:  wdata = add_sum;
         WR_ACC:  wdata = acc_ff;
         default: wdata = x_ff;
      endcase
   end

   // Partial sum memory with registered read data.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[addr] <= wdata;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[addr];
      end
   end

   // Operand order follows the accumulation direction of each phase.
   assign add_a = cmd.fold_mode ? acc_ff : rd_ff;
   assign add_b = cmd.fold_mode ? rd_ff : acc_ff;

   pfs_fadd u_fadd (
      .clock (clock),
      .reset (reset),
      .start (cmd.add_start),
      .op_a  (add_a),
      .op_b  (add_b),
      .done  (add_done),
      .sum   (add_sum)
   );

   // Item, accumulator and level registers.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         x_ff    <= req_value_bits;
         acc_ff  <= req_value_bits;
         last_ff <= req_is_last;
         ones_ff <= ones_now;
      end else if (cmd.acc_sum) begin
         acc_ff <= add_sum;
      end else if (cmd.fold_init) begin
         acc_ff <= 64'd0;
      end
      if (cmd.take || cmd.fold_init) begin
         lvl_ff <= '0;
      end else if (cmd.lvl_inc) begin
         lvl_ff <= lvl_ff + LW'(1);
      end
      if (cmd.emit) begin
         total_ff      <= acc_ff;
         item_total_ff <= count_ff;
      end
   end

   // Item count and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.take) begin
            count_ff <= count_inc;
         end else if (cmd.emit) begin
            count_ff <= 32'd0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.item_no_carry = !count_ff[0];
      status.last          = last_ff;
      status.lvl_past_top  = lvl_ff > LW'(TOP);
      status.lvl_lt_ones   = 7'(lvl_ff) < 7'(ones_ff);
      status.fold_end      = lvl_ff >= LW'(FOLD_N);
      status.cnt_bit       = count_sh[0];
      status.add_done      = add_done;
      status.rsp_full      = rsp_valid_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_total_bits = total_ff;
   assign rsp_item_total = item_total_ff;

endmodule

>>> hw/rtl/pairwise_float_sum_stream.sv
// Pairwise binary64 summation of an item stream, one item worked on at a time. An item
// whose index (count before it) is even simply loads level 0; otherwise it makes
// min(t, LEVELS) carry additions, t being the trailing ones of the index, each through
// the shared adder after a registered read of the partial sum memory. The item marked
// last then folds every level whose bit is set in the item count, scanning the clear
// levels in between, and the total comes out with the item count. The result sits in
// an output register, so the next item is taken while it waits. Streams of 2^LEVELS
// items or more do not give the true pairwise sum.
// Uses pfs_pkg, pfs_if, pfs_ctrl, pfs_dpath.
module pairwise_float_sum_stream
   import pfs_pkg::*;
#(
   parameter int unsigned LEVELS = 32
) (
   input  logic    clock,
   input  logic    reset,
   pfs_req_if.sink req_chan,
   pfs_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;

   pfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pfs_dpath #(
      .LEVELS (LEVELS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_value_bits (req_chan.value_bits),
      .req_is_last    (req_chan.is_last),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_total_bits (rsp_chan.total_bits),
      .rsp_item_total (rsp_chan.item_total)
   );

endmodule

>>> hw/rtl/pfs_check.sv
// Port-level checks for the pairwise float sum stream block, bound to the top level.
// Sees only the channel signals; no package dependency.
module pfs_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_total_bits,
   input logic [31:0] rsp_item_total
);

   // A result waiting for its taker stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_total_bits) && $stable(rsp_item_total))
      else $error("stalled result changed");

   // Every stream holds at least one item.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item_total != 32'd0)
      else $error("result with zero item count");

   // The block works on one item at a time: no accept in the cycle after an accept.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while the previous one is still at work");

endmodule

bind pairwise_float_sum_stream pfs_check u_pfs_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_total_bits (rsp_chan.total_bits),
   .rsp_item_total (rsp_chan.item_total)
);
